@@ rtl/sqdr_pkg.sv @@
// Shared types, constants and codes for the range-query block.
`timescale 1ns / 1ps
package sqdr_pkg;
	localparam int DEPTH      = 1024;
	localparam int IDX_W      = $clog2(DEPTH);
	localparam int BS_W       = 11;
	localparam int BS_MAX     = 1024;
	localparam int BS_RESET   = 33;
	localparam int VAL_W      = 32;
	localparam int ACC_W      = 64;
	localparam int FIFO_DEPTH = 2;
	localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
	localparam int DIV_CNT_W  = $clog2(IDX_W + 1);

	typedef enum logic [1:0] {OP_SET, OP_SUM, OP_ADD, OP_MAX} op_t;

	typedef struct packed {
		op_t                     operation;
		logic [IDX_W-1:0]        index_low;
		logic [IDX_W-1:0]        index_high;
		logic signed [VAL_W-1:0] value;
	} in_t;

	typedef struct packed {
		logic signed [ACC_W-1:0] answer;
		logic                    range_error;
	} out_t;

	typedef struct packed {
		op_t                     op;
		logic                    err;
		logic [IDX_W-1:0]        lo;
		logic [IDX_W-1:0]        hi;
		logic [IDX_W-1:0]        lb;
		logic [IDX_W-1:0]        lo_off;
		logic [IDX_W-1:0]        rb;
		logic [IDX_W-1:0]        hi_start;
		logic [BS_W-1:0]         bs;
		logic signed [VAL_W-1:0] val;
	} cmd_t;

	typedef struct packed {
		logic clearing;
		logic busy;
	} back_stat_t;

	typedef enum logic [1:0] {F_IDLE, F_DIV, F_PUSH} front_state_t;

	typedef enum logic [2:0] {
		B_CLEAR, B_IDLE, B_ERD, B_EEX, B_BRD, B_BEX, B_RES
	} back_state_t;
endpackage

@@ rtl/sqdr_ram.sv @@
// Generic single-port RAM with registered read.
`timescale 1ns / 1ps
module sqdr_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end
endmodule

@@ rtl/sqdr_div.sv @@
// Restoring divider, one quotient bit per cycle: index by block size.
`timescale 1ns / 1ps
module sqdr_div import sqdr_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [IDX_W-1:0] dividend,
	input  logic [BS_W-1:0]  divisor,
	output logic             done,
	output logic [IDX_W-1:0] quot,
	output logic [IDX_W-1:0] rem
);
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [BS_W-1:0]      r_q;
	logic [IDX_W-1:0]     n_q;
	logic [IDX_W-1:0]     q_q;
	logic [BS_W-1:0]      trial;
	logic                 ge;

	assign trial = {r_q[BS_W-2:0], n_q[IDX_W-1]};
	assign ge    = trial >= divisor;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= DIV_CNT_W'(IDX_W);
		end else if (cnt_q != '0) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			r_q <= '0;
			n_q <= dividend;
			q_q <= '0;
		end else if (cnt_q != '0) begin
			r_q <= ge ? trial - divisor : trial;
			n_q <= {n_q[IDX_W-2:0], 1'b0};
			q_q <= {q_q[IDX_W-2:0], ge};
		end
	end

	assign done = cnt_q == '0;
	assign quot = q_q;
	assign rem  = r_q[IDX_W-1:0];
endmodule

@@ rtl/sqdr_front.sv @@
// Front end: takes requests, works out block numbers and offsets, queues commands.
`timescale 1ns / 1ps
module sqdr_front import sqdr_pkg::*; (
	input  logic            clk,
	input  logic            arst_n,
	input  logic [BS_W-1:0] blk_len,
	input  logic            clearing,
	input  logic            in_valid,
	output logic            in_ready,
	input  in_t             in_data,
	input  logic            fifo_full,
	output logic            push,
	output cmd_t            cmd
);
	front_state_t    state_q, state_d;
	in_t             req_q;
	logic [BS_W-1:0] bs_q;
	logic [BS_W-1:0] bs_eff;
	logic            accept;
	logic            lo_done, hi_done;
	logic [IDX_W-1:0] lo_quot, lo_rem, hi_quot, hi_rem;

	always_comb begin
		if (blk_len == '0) begin
			bs_eff = BS_W'(1);
		end else if (blk_len > BS_W'(BS_MAX)) begin
			bs_eff = BS_W'(BS_MAX);
		end else begin
			bs_eff = blk_len;
		end
	end

	assign accept = in_valid && in_ready;

	sqdr_div u_div_lo (
		.clk(clk), .arst_n(arst_n), .start(accept), .dividend(in_data.index_low),
		.divisor(accept ? bs_eff : bs_q), .done(lo_done), .quot(lo_quot), .rem(lo_rem)
	);

	sqdr_div u_div_hi (
		.clk(clk), .arst_n(arst_n), .start(accept), .dividend(in_data.index_high),
		.divisor(accept ? bs_eff : bs_q), .done(hi_done), .quot(hi_quot), .rem(hi_rem)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_q <= in_data;
			bs_q  <= bs_eff;
		end
	end

	always_comb begin
		state_d  = state_q;
		in_ready = 1'b0;
		push     = 1'b0;
		case (state_q)
			F_IDLE: begin
				in_ready = !clearing;
				if (in_valid && !clearing) begin
					state_d = F_DIV;
				end
			end
			F_DIV: begin
				if (lo_done && hi_done) begin
					state_d = F_PUSH;
				end
			end
			F_PUSH: begin
				if (!fifo_full) begin
					push    = 1'b1;
					state_d = F_IDLE;
				end
			end
			default: state_d = F_IDLE;
		endcase
	end

	always_comb begin
		cmd.op       = req_q.operation;
		cmd.err      = req_q.operation != OP_SET && req_q.index_low > req_q.index_high;
		cmd.lo       = req_q.index_low;
		cmd.hi       = req_q.index_high;
		cmd.lb       = lo_quot;
		cmd.lo_off   = lo_rem;
		cmd.rb       = hi_quot;
		cmd.hi_start = req_q.index_high - hi_rem;
		cmd.bs       = bs_q;
		cmd.val      = req_q.value;
	end
endmodule

@@ rtl/sqdr_fifo.sv @@
// Short command queue between front and back.
`timescale 1ns / 1ps
module sqdr_fifo import sqdr_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cmd_t push_data,
	input  logic pop,
	output cmd_t pop_data,
	output logic full,
	output logic empty
);
	cmd_t                  entries_q [FIFO_DEPTH];
	logic [FIFO_PTR_W-1:0] wptr_q, rptr_q;
	logic [FIFO_PTR_W:0]   count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wptr_q <= wptr_q + 1'b1;
			end
			if (pop) begin
				rptr_q <= rptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wptr_q] <= push_data;
		end
	end

	assign pop_data = entries_q[rptr_q];
	assign full     = count_q == (FIFO_PTR_W+1)'(FIFO_DEPTH);
	assign empty    = count_q == '0;
endmodule

@@ rtl/sqdr_back.sv @@
// Back end: clears the stores after reset, then walks elements and block sums.
`timescale 1ns / 1ps
module sqdr_back import sqdr_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       fifo_empty,
	input  cmd_t       cmd_in,
	output logic       pop,
	output logic       out_valid,
	input  logic       out_ready,
	output out_t       out_data,
	output back_stat_t stat
);
	back_state_t             state_q, state_d;
	logic [IDX_W-1:0]        clr_q;
	cmd_t                    cmd_q, cmd_d;
	logic [IDX_W-1:0]        i_q, i_d, blk_q, blk_d, off_q, off_d;
	logic signed [ACC_W-1:0] acc_q, acc_d;
	logic                    first_q, first_d;

	logic                    elem_we, bsum_we;
	logic [IDX_W-1:0]        elem_addr, bsum_addr;
	logic [VAL_W-1:0]        elem_wdata, elem_rdata;
	logic [ACC_W-1:0]        bsum_wdata, bsum_rdata;
	logic [VAL_W-1:0]        new_elem;
	logic signed [ACC_W-1:0] old_sx, new_sx;
	logic                    last, blk_end, clearing;

	assign clearing = state_q == B_CLEAR;

	sqdr_ram #(.WIDTH(VAL_W), .DEPTH(DEPTH)) u_elem_ram (
		.clk(clk), .we(elem_we), .addr(elem_addr), .wdata(elem_wdata), .rdata(elem_rdata)
	);

	sqdr_ram #(.WIDTH(ACC_W), .DEPTH(DEPTH)) u_bsum_ram (
		.clk(clk), .we(bsum_we), .addr(bsum_addr), .wdata(bsum_wdata), .rdata(bsum_rdata)
	);

	assign new_elem   = (cmd_q.op == OP_SET) ? cmd_q.val : elem_rdata + cmd_q.val;
	assign old_sx     = {{(ACC_W-VAL_W){elem_rdata[VAL_W-1]}}, elem_rdata};
	assign new_sx     = {{(ACC_W-VAL_W){new_elem[VAL_W-1]}}, new_elem};
	assign last       = i_q == cmd_q.hi;
	assign blk_end    = {1'b0, off_q} == cmd_q.bs - 1'b1;
	assign elem_addr  = clearing ? clr_q : i_q;
	assign bsum_addr  = clearing ? clr_q : blk_q;
	assign elem_wdata = clearing ? '0 : new_elem;
	assign bsum_wdata = clearing ? '0 : bsum_rdata + ACC_W'(new_sx - old_sx);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_CLEAR;
			clr_q   <= '0;
		end else begin
			state_q <= state_d;
			if (clearing) begin
				clr_q <= clr_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		cmd_q   <= cmd_d;
		i_q     <= i_d;
		blk_q   <= blk_d;
		off_q   <= off_d;
		acc_q   <= acc_d;
		first_q <= first_d;
	end

	always_comb begin
		state_d = state_q;
		cmd_d   = cmd_q;
		i_d     = i_q;
		blk_d   = blk_q;
		off_d   = off_q;
		acc_d   = acc_q;
		first_d = first_q;
		pop     = 1'b0;
		elem_we = 1'b0;
		bsum_we = 1'b0;
		case (state_q)
			B_CLEAR: begin
				elem_we = 1'b1;
				bsum_we = 1'b1;
				if (clr_q == IDX_W'(DEPTH - 1)) begin
					state_d = B_IDLE;
				end
			end
			B_IDLE: begin
				if (!fifo_empty) begin
					pop     = 1'b1;
					cmd_d   = cmd_in;
					i_d     = cmd_in.lo;
					blk_d   = cmd_in.lb;
					off_d   = cmd_in.lo_off;
					acc_d   = '0;
					first_d = 1'b1;
					state_d = cmd_in.err ? B_RES : B_ERD;
				end
			end
			B_ERD: state_d = B_EEX;
			B_EEX: begin
				// step to the next element, tracking block number and offset
				i_d     = i_q + 1'b1;
				off_d   = blk_end ? '0 : off_q + 1'b1;
				blk_d   = blk_end ? blk_q + 1'b1 : blk_q;
				state_d = last ? B_IDLE : B_ERD;
				case (cmd_q.op)
					OP_SET: begin
						elem_we = 1'b1;
						bsum_we = 1'b1;
						state_d = B_IDLE;
					end
					OP_ADD: begin
						elem_we = 1'b1;
						bsum_we = 1'b1;
					end
					OP_SUM: begin
						acc_d = acc_q + old_sx;
						if (last) begin
							state_d = B_RES;
						end else if (blk_q == cmd_q.lb && blk_end &&
								({1'b0, blk_q} + 1'b1 < {1'b0, cmd_q.rb})) begin
							// whole blocks in between come from the block sums
							state_d = B_BRD;
						end
					end
					OP_MAX: begin
						first_d = 1'b0;
						if (first_q || old_sx > acc_q) begin
							acc_d = old_sx;
						end
						if (last) begin
							state_d = B_RES;
						end
					end
					default: state_d = B_IDLE;
				endcase
			end
			B_BRD: state_d = B_BEX;
			B_BEX: begin
				acc_d = acc_q + bsum_rdata;
				if (blk_q == cmd_q.rb - 1'b1) begin
					i_d     = cmd_q.hi_start;
					blk_d   = cmd_q.rb;
					off_d   = '0;
					state_d = B_ERD;
				end else begin
					blk_d   = blk_q + 1'b1;
					state_d = B_BRD;
				end
			end
			B_RES: begin
				if (out_ready) begin
					state_d = B_IDLE;
				end
			end
			default: state_d = B_IDLE;
		endcase
	end

	assign out_valid            = state_q == B_RES;
	assign out_data.answer      = acc_q;
	assign out_data.range_error = cmd_q.err;
	assign stat.clearing        = clearing;
	assign stat.busy            = state_q != B_IDLE;
endmodule

@@ rtl/sqrt_decomposition_range_query_top.sv @@
// Top level: block size register, front end, command queue and back end.
// The front divides both indices by the block size, one bit a cycle, then pushes the
// command into the queue; the back pops it, reads and executes each element walked and
// reads each whole block sum, then gives any result; a point set writes one element.
// The back works on one request at a time, so the time a request takes follows the element
// and block count of the range; the front takes the next request only after its push.
// Reset: asynchronous; a clearing pass zeroes both stores, no request taken.
`timescale 1ns / 1ps
module sqrt_decomposition_range_query_top import sqdr_pkg::*; (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            cfg_we,
	input  logic [BS_W-1:0] cfg_wdata,
	input  logic            in_valid,
	output logic            in_ready,
	input  in_t             in_data,
	output logic            out_valid,
	input  logic            out_ready,
	output out_t            out_data
);
	logic [BS_W-1:0] blk_len_q;
	back_stat_t      stat;
	cmd_t            push_cmd, pop_cmd;
	logic            push, pop, fifo_full, fifo_empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			blk_len_q <= BS_W'(BS_RESET);
		end else if (cfg_we) begin
			blk_len_q <= cfg_wdata;
		end
	end

	sqdr_front u_front (
		.clk(clk), .arst_n(arst_n), .blk_len(blk_len_q), .clearing(stat.clearing),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.fifo_full(fifo_full), .push(push), .cmd(push_cmd)
	);

	sqdr_fifo u_fifo (
		.clk(clk), .arst_n(arst_n), .push(push), .push_data(push_cmd),
		.pop(pop), .pop_data(pop_cmd), .full(fifo_full), .empty(fifo_empty)
	);

	sqdr_back u_back (
		.clk(clk), .arst_n(arst_n), .fifo_empty(fifo_empty), .cmd_in(pop_cmd), .pop(pop),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data), .stat(stat)
	);

	a_no_req_while_clearing: assert property (@(posedge clk) disable iff (!arst_n)
		stat.clearing |-> !in_ready) else $error("request taken during clearing pass");

	a_error_answer_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.range_error |-> out_data.answer == '0)
		else $error("range error with non-zero answer");

	a_result_needs_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> stat.busy && !stat.clearing) else $error("result while back idle");

	a_pop_not_empty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !fifo_empty) else $error("pop from empty queue");
endmodule
